// ----- src/suffix_prefix_overlap_assert.svh -----
// assertion macros for the suffix-prefix overlap block
`ifndef SUFFIX_PREFIX_OVERLAP_ASSERT_SVH
`define SUFFIX_PREFIX_OVERLAP_ASSERT_SVH
`ifndef SYNTH
`define SPO_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spo check failed: same cycle");
`define SPO_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spo check failed: next cycle");
`else
`define SPO_ASSERT_IMP(lbl, ante, cons)
`define SPO_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- src/spo_pkg.sv -----
// shared types and constants for the suffix-prefix overlap block
package spo_pkg;

    localparam int SYM_W = 8;
    localparam int CMP_W = 20;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_LENGTH = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_STREAM,
        ST_FLUSH,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic             load;
        logic             stream;
        logic             scan;
        logic [SYM_W-1:0] sym_a;
    } cell_ctrl_t;

endpackage

// ----- src/suffix_prefix_overlap.sv -----
// top level of the suffix-prefix overlap block
// Symbol writes and length writes are taken while idle and keep busy low. A query
// whose read indices are valid holds busy while it loads the second read into the
// cell row, streams the symbols of the first read past the cells, flushes and walks
// the match flags out of the top cell; the single read port of the symbol memory
// serves both the load and the stream. A query naming a bad read answers in the
// next cycle with index_error set. Every result shows on done for one cycle and
// cannot be held off, so the receiver must take it then.
module suffix_prefix_overlap #(
    parameter int MAX_READS_STORED = 16,
    parameter int MAX_READ_LEN     = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] operation,
    input  logic [3:0] read_index,
    input  logic [4:0] position,
    input  logic [7:0] symbol,
    input  logic [5:0] read_length,
    input  logic [3:0] second_read,
    output logic       done,
    output logic [5:0] overlap_length,
    output logic       index_error,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [4:0] cfg_data
);

    localparam int N      = MAX_READ_LEN;
    localparam int CW     = spo_pkg::CMP_W;
    localparam int AW     = $clog2(MAX_READS_STORED * N);
    localparam int RIDX_W = $clog2(MAX_READS_STORED);
    localparam int POS_W  = (N > 1) ? $clog2(N) : 1;
    localparam int LEN_W  = $clog2(N + 1);

    spo_pkg::state_t     state_reg, state_next;
    logic [POS_W-1:0]    cnt_reg, cnt_next;
    logic [LEN_W-1:0]    scan_reg, scan_next;
    logic [AW-1:0]       base_a_reg, base_a_next;
    logic [AW-1:0]       base_b_reg, base_b_next;
    logic                pend_reg, pend_next;
    logic                pend_load_reg, pend_load_next;
    logic                pend_live_reg, pend_live_next;
    logic                done_reg, done_next;
    logic [5:0]          ovl_reg, ovl_next;
    logic                err_reg, err_next;
    logic [4:0]          reads_in_use_reg;

    logic                accept;
    logic [CW-1:0]       ra_w, rb_w, pos_w, len_w, in_use_w, len_sat;
    logic                ra_ok, rb_ok, pos_ok, query_err;
    logic [CW-1:0]       waddr_w;
    logic [AW-1:0]       sym_raddr;
    logic [spo_pkg::SYM_W-1:0] sym_rdata;
    logic [LEN_W-1:0]    la, lb;
    logic                sym_we, len_we;
    logic                top_flag;
    logic                stream_last;
    spo_pkg::cell_ctrl_t ctrl;

    assign accept   = start && !busy;
    assign ra_w     = CW'(read_index);
    assign rb_w     = CW'(second_read);
    assign pos_w    = CW'(position);
    assign len_w    = CW'(read_length);
    assign in_use_w = CW'(reads_in_use_reg);
    assign ra_ok    = ra_w < CW'(MAX_READS_STORED);
    assign rb_ok    = rb_w < CW'(MAX_READS_STORED);
    assign pos_ok   = pos_w < CW'(N);
    assign query_err = !(ra_ok && rb_ok && (ra_w < in_use_w) && (rb_w < in_use_w));
    assign len_sat  = (len_w > CW'(N)) ? CW'(N) : len_w;
    assign waddr_w  = ra_w * CW'(N) + pos_w;

    assign sym_we = accept && (operation == spo_pkg::OP_WRITE) && ra_ok && pos_ok;
    assign len_we = accept && (operation == spo_pkg::OP_LENGTH) && ra_ok;

    assign sym_raddr = (state_reg == spo_pkg::ST_LOAD) ? base_b_reg + AW'(cnt_reg)
                                                       : base_a_reg + AW'(cnt_reg);
    assign stream_last = (LEN_W'(cnt_reg) + LEN_W'(1)) == la;

    spo_store #(
        .MAX_READS_STORED (MAX_READS_STORED),
        .MAX_READ_LEN     (MAX_READ_LEN)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .sym_we     (sym_we),
        .sym_waddr  (AW'(waddr_w)),
        .sym_wdata  (symbol),
        .sym_raddr  (sym_raddr),
        .sym_rdata  (sym_rdata),
        .len_we     (len_we),
        .len_widx   (RIDX_W'(ra_w)),
        .len_wdata  (LEN_W'(len_sat)),
        .len_re     (accept),
        .len_ridx_a (RIDX_W'(ra_w)),
        .len_ridx_b (RIDX_W'(rb_w)),
        .len_a      (la),
        .len_b      (lb)
    );

    always_comb
    begin
        ctrl.load   = pend_reg && pend_load_reg;
        ctrl.stream = pend_reg && !pend_load_reg;
        ctrl.scan   = (state_reg == spo_pkg::ST_SCAN) && !top_flag && (scan_reg != '0);
        ctrl.sym_a  = sym_rdata;
    end

    spo_chain #(
        .N (N)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .feed_sym  (sym_rdata),
        .feed_live (pend_live_reg),
        .top_flag  (top_flag)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        scan_next      = scan_reg;
        base_a_next    = base_a_reg;
        base_b_next    = base_b_reg;
        pend_next      = 1'b0;
        pend_load_next = pend_load_reg;
        pend_live_next = pend_live_reg;
        done_next      = 1'b0;
        ovl_next       = ovl_reg;
        err_next       = err_reg;
        unique case (state_reg)
            spo_pkg::ST_IDLE:
            begin
                if (accept && (operation == spo_pkg::OP_QUERY))
                begin
                    if (query_err)
                    begin
                        done_next = 1'b1;
                        ovl_next  = '0;
                        err_next  = 1'b1;
                    end
                    else
                    begin
                        state_next  = spo_pkg::ST_LOAD;
                        cnt_next    = POS_W'(N - 1);
                        base_a_next = AW'(ra_w * CW'(N));
                        base_b_next = AW'(rb_w * CW'(N));
                    end
                end
            end
            spo_pkg::ST_LOAD:
            begin
                // second read enters top symbol first
                pend_next      = 1'b1;
                pend_load_next = 1'b1;
                pend_live_next = LEN_W'(cnt_reg) < lb;
                if (cnt_reg == '0)
                begin
                    state_next = (la == '0) ? spo_pkg::ST_FLUSH : spo_pkg::ST_STREAM;
                end
                else
                begin
                    cnt_next = cnt_reg - POS_W'(1);
                end
            end
            spo_pkg::ST_STREAM:
            begin
                pend_next      = 1'b1;
                pend_load_next = 1'b0;
                if (stream_last)
                begin
                    state_next = spo_pkg::ST_FLUSH;
                end
                else
                begin
                    cnt_next = cnt_reg + POS_W'(1);
                end
            end
            spo_pkg::ST_FLUSH:
            begin
                state_next = spo_pkg::ST_SCAN;
                scan_next  = LEN_W'(N);
            end
            spo_pkg::ST_SCAN:
            begin
                // top cell flag stands for overlap scan_reg
                if (top_flag || (scan_reg == '0))
                begin
                    state_next = spo_pkg::ST_IDLE;
                    done_next  = 1'b1;
                    ovl_next   = top_flag ? 6'(scan_reg) : '0;
                    err_next   = 1'b0;
                end
                else
                begin
                    scan_next = scan_reg - LEN_W'(1);
                end
            end
            default:
            begin
                state_next = spo_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spo_pkg::ST_IDLE;
            cnt_reg       <= '0;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            pend_load_reg <= 1'b0;
            pend_live_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            scan_reg      <= scan_next;
            pend_reg      <= pend_next;
            pend_load_reg <= pend_load_next;
            pend_live_reg <= pend_live_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_a_reg <= base_a_next;
        base_b_reg <= base_b_next;
        ovl_reg    <= ovl_next;
        err_reg    <= err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reads_in_use_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            reads_in_use_reg <= cfg_data;
        end
    end

    assign cfg_ready      = 1'b1;
    assign busy           = state_reg != spo_pkg::ST_IDLE;
    assign done           = done_reg;
    assign overlap_length = ovl_reg;
    assign index_error    = err_reg;

`include "suffix_prefix_overlap_assert.svh"

    `SPO_ASSERT_IMP(a_done_idle, done, !busy)
    `SPO_ASSERT_NXT(a_good_query_busy, accept && (operation == spo_pkg::OP_QUERY) && !query_err, busy && !done)
    `SPO_ASSERT_NXT(a_bad_query_flag, accept && (operation == spo_pkg::OP_QUERY) && query_err, done && index_error && (overlap_length == 6'd0))
    `SPO_ASSERT_IMP(a_err_zero, done && index_error, overlap_length == 6'd0)

endmodule

// ----- src/spo_cell.sv -----
// one cell of the match chain: a prefix symbol, a live bit and a match flag
module spo_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  spo_pkg::cell_ctrl_t            ctrl,
    input  logic [spo_pkg::SYM_W-1:0]      sym_in,
    input  logic                           live_in,
    input  logic                           flag_in,
    output logic [spo_pkg::SYM_W-1:0]      sym_out,
    output logic                           live_out,
    output logic                           flag_out
);

    logic [spo_pkg::SYM_W-1:0] sym_reg;
    logic                      live_reg;
    logic                      flag_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            sym_reg <= sym_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= 1'b0;
            flag_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            live_reg <= live_in;
            flag_reg <= 1'b0;
        end
        else if (ctrl.stream)
        begin
            flag_reg <= flag_in && live_reg && (ctrl.sym_a == sym_reg);
        end
        else if (ctrl.scan)
        begin
            flag_reg <= flag_in;
        end
    end

    assign sym_out  = sym_reg;
    assign live_out = live_reg;
    assign flag_out = flag_reg;

endmodule

// ----- src/spo_chain.sv -----
// row of match cells, each handing symbol, live bit and flag to the next
module spo_chain #(
    parameter int N = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  spo_pkg::cell_ctrl_t       ctrl,
    input  logic [spo_pkg::SYM_W-1:0] feed_sym,
    input  logic                      feed_live,
    output logic                      top_flag
);

    logic [spo_pkg::SYM_W-1:0] sym_w  [N];
    logic                      live_w [N];
    logic                      flag_w [N];

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic [spo_pkg::SYM_W-1:0] sym_src;
        logic                      live_src;
        logic                      flag_src;

        if (i == 0)
        begin : g_head
            // a new match may start at every streamed symbol
            assign sym_src  = feed_sym;
            assign live_src = feed_live;
            assign flag_src = ctrl.stream;
        end
        else
        begin : g_body
            assign sym_src  = sym_w[i-1];
            assign live_src = live_w[i-1];
            assign flag_src = flag_w[i-1];
        end

        spo_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .sym_in   (sym_src),
            .live_in  (live_src),
            .flag_in  (flag_src),
            .sym_out  (sym_w[i]),
            .live_out (live_w[i]),
            .flag_out (flag_w[i])
        );
    end

    assign top_flag = flag_w[N-1];

endmodule

// ----- src/spo_store.sv -----
// symbol memory and read length store
module spo_store #(
    parameter  int MAX_READS_STORED = 16,
    parameter  int MAX_READ_LEN     = 32,
    localparam int AW     = $clog2(MAX_READS_STORED * MAX_READ_LEN),
    localparam int RIDX_W = $clog2(MAX_READS_STORED),
    localparam int LEN_W  = $clog2(MAX_READ_LEN + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      sym_we,
    input  logic [AW-1:0]             sym_waddr,
    input  logic [spo_pkg::SYM_W-1:0] sym_wdata,
    input  logic [AW-1:0]             sym_raddr,
    output logic [spo_pkg::SYM_W-1:0] sym_rdata,
    input  logic                      len_we,
    input  logic [RIDX_W-1:0]         len_widx,
    input  logic [LEN_W-1:0]          len_wdata,
    input  logic                      len_re,
    input  logic [RIDX_W-1:0]         len_ridx_a,
    input  logic [RIDX_W-1:0]         len_ridx_b,
    output logic [LEN_W-1:0]          len_a,
    output logic [LEN_W-1:0]          len_b
);

    logic [spo_pkg::SYM_W-1:0] sym_mem [MAX_READS_STORED * MAX_READ_LEN];
    logic [spo_pkg::SYM_W-1:0] sym_rdata_reg;
    logic [LEN_W-1:0]          len_mem [MAX_READS_STORED];
    logic [MAX_READS_STORED-1:0] len_vld_reg;
    logic [LEN_W-1:0]          len_a_reg;
    logic [LEN_W-1:0]          len_b_reg;

    always_ff @(posedge clk)
    begin
        if (sym_we)
        begin
            sym_mem[sym_waddr] <= sym_wdata;
        end
        sym_rdata_reg <= sym_mem[sym_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[len_widx] <= len_wdata;
        end
        if (len_re)
        begin
            len_a_reg <= len_vld_reg[len_ridx_a] ? len_mem[len_ridx_a] : '0;
            len_b_reg <= len_vld_reg[len_ridx_b] ? len_mem[len_ridx_b] : '0;
        end
    end

    // a length never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_vld_reg <= '0;
        end
        else if (len_we)
        begin
            len_vld_reg[len_widx] <= 1'b1;
        end
    end

    assign sym_rdata = sym_rdata_reg;
    assign len_a     = len_a_reg;
    assign len_b     = len_b_reg;

endmodule

// ----- bench/suffix_prefix_overlap_tb.sv -----
// testbench for the suffix-prefix overlap block: directed and random words against a predictor
`timescale 1ns / 1ps

module suffix_prefix_overlap_tb;

    localparam int NUM_READS   = 16;
    localparam int READ_LEN    = 32;
    localparam int SETTLE      = 3 * READ_LEN + 8;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [5:0] overlap;
        logic       index_error;
    } overlap_result_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] operation;
    logic [3:0] read_index;
    logic [4:0] position;
    logic [7:0] symbol;
    logic [5:0] read_length;
    logic [3:0] second_read;
    logic       done;
    logic [5:0] overlap_length;
    logic       index_error;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [4:0] cfg_data;

    logic [7:0] read_syms [NUM_READS][READ_LEN];
    logic [5:0] read_lens [NUM_READS];
    logic [4:0] reads_limit;

    overlap_result_t pending_overlaps [$];
    int  mismatches;
    int  words_sent;
    int  cycles;
    bit  no_idle;

    suffix_prefix_overlap dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .read_index     (read_index),
        .position       (position),
        .symbol         (symbol),
        .read_length    (read_length),
        .second_read    (second_read),
        .done           (done),
        .overlap_length (overlap_length),
        .index_error    (index_error),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // longest suffix of read a equal to a prefix of read b
    function automatic logic [5:0] predict_overlap(input int a, input int b);
        int  la;
        int  lb;
        int  lim;
        int  best;
        bit  hit;
        la   = int'(read_lens[a]);
        lb   = int'(read_lens[b]);
        lim  = (la < lb) ? la : lb;
        best = 0;
        for (int k = 1; k <= lim; k++)
        begin
            hit = 1'b1;
            for (int t = 0; t < k; t++)
                if (read_syms[a][la - k + t] != read_syms[b][t])
                    hit = 1'b0;
            if (hit)
                best = k;
        end
        return best[5:0];
    endfunction

    task automatic absorb_word(input logic [1:0] op, input logic [3:0] ra,
                               input logic [4:0] pos, input logic [7:0] sym,
                               input logic [5:0] len, input logic [3:0] rb);
        overlap_result_t want;
        case (op)
            spo_pkg::OP_WRITE:  read_syms[ra][pos] = sym;
            spo_pkg::OP_LENGTH: read_lens[ra] = (len > READ_LEN) ? 6'(READ_LEN) : len;
            spo_pkg::OP_QUERY:
            begin
                want.index_error = (ra >= reads_limit) || (rb >= reads_limit);
                want.overlap     = want.index_error ? 6'd0
                                                    : predict_overlap(int'(ra), int'(rb));
                pending_overlaps.push_back(want);
            end
            default: ;
        endcase
    endtask

    task automatic send_word(input logic [1:0] op, input logic [3:0] ra,
                             input logic [4:0] pos, input logic [7:0] sym,
                             input logic [5:0] len, input logic [3:0] rb);
        int gap;
        gap = no_idle ? 0 : int'($urandom_range(0, 19));
        repeat (gap)
        begin
            @(negedge clk);
            start = 1'b0;
        end
        @(negedge clk);
        start       = 1'b1;
        operation   = op;
        read_index  = ra;
        position    = pos;
        symbol      = sym;
        read_length = len;
        second_read = rb;
        do @(posedge clk); while (busy);
        absorb_word(op, ra, pos, sym, len, rb);
        words_sent++;
    endtask

    task automatic write_sym(input int ra, input int pos, input logic [7:0] sym);
        send_word(spo_pkg::OP_WRITE, 4'(ra), 5'(pos), sym, 6'($urandom), 4'($urandom));
    endtask

    task automatic set_len(input int ra, input int len);
        send_word(spo_pkg::OP_LENGTH, 4'(ra), 5'($urandom), 8'($urandom), 6'(len),
                  4'($urandom));
    endtask

    task automatic query(input int ra, input int rb);
        send_word(spo_pkg::OP_QUERY, 4'(ra), 5'($urandom), 8'($urandom), 6'($urandom),
                  4'(rb));
    endtask

    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (pending_overlaps.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_reads_in_use(input logic [4:0] value);
        drain();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        reads_limit = value;
        @(negedge clk);
        cfg_valid = 1'b0;
        cfg_data  = 5'($urandom);
    endtask

    function automatic int pick_read();
        int top;
        top = (int'(reads_limit) > NUM_READS) ? NUM_READS : int'(reads_limit);
        if (top > 0 && $urandom_range(0, 99) < 85)
            return int'($urandom_range(0, top - 1));
        return int'($urandom_range(0, NUM_READS - 1));
    endfunction

    function automatic logic [7:0] pick_symbol();
        if ($urandom_range(0, 99) < 70)
            return 8'($urandom_range(0, 3));
        return 8'($urandom);
    endfunction

    // copies a suffix of one read onto another's prefix, may spoil a symbol, then queries
    task automatic plant_overlap();
        int a;
        int b;
        int la;
        int lb;
        int k;
        a  = pick_read();
        b  = pick_read();
        la = $urandom_range(1, READ_LEN);
        k  = $urandom_range(1, la);
        lb = (a == b) ? la : $urandom_range(k, READ_LEN);
        set_len(a, (la == READ_LEN && $urandom_range(0, 1)) ? $urandom_range(33, 63) : la);
        if (a != b)
            set_len(b, lb);
        for (int t = 0; t < k; t++)
            write_sym(b, t, read_syms[a][la - k + t]);
        if ($urandom_range(0, 99) < 15)
            write_sym(b, $urandom_range(0, k - 1), pick_symbol());
        query(a, b);
    endtask

    task automatic test_reset_state();
        query(0, 0);
        query(15, 15);
        set_reads_in_use(5'd16);
    endtask

    task automatic fill_store();
        for (int r = 0; r < NUM_READS; r++)
            for (int p = 0; p < READ_LEN; p++)
                write_sym(r, p, 8'($urandom_range(0, 3)));
    endtask

    task automatic test_special_cases();
        // lengths still cleared from reset
        query(0, 15);
        set_len(0, 32);
        query(0, 0);
        set_len(2, 63);
        query(2, 2);
        set_len(1, 33);
        query(1, 0);
        set_len(3, 1);
        set_len(4, 1);
        write_sym(3, 0, 8'hff);
        write_sym(4, 0, 8'hff);
        query(3, 4);
        write_sym(3, 0, 8'h00);
        write_sym(4, 0, 8'h00);
        query(3, 4);
        write_sym(4, 0, 8'hff);
        query(3, 4);
        set_len(5, 0);
        query(5, 0);
        query(0, 5);
        send_word(OP_UNUSED, 4'd0, 5'd0, 8'hff, 6'd63, 4'd0);
        query(15, 0);
    endtask

    task automatic test_index_limits();
        set_reads_in_use(5'd15);
        query(15, 0);
        query(0, 15);
        query(14, 14);
        set_reads_in_use(5'd31);
        query(15, 15);
        query(0, 15);
    endtask

    task automatic test_random_phase(input logic [4:0] limit, input int count);
        int first;
        int pick;
        set_reads_in_use(limit);
        first = words_sent;
        while (words_sent - first < count)
        begin
            if ($urandom_range(0, 49) == 0)
                no_idle = !no_idle;
            pick = $urandom_range(0, 99);
            if (pick < 35)
                plant_overlap();
            else if (pick < 55)
                write_sym($urandom_range(0, 15), $urandom_range(0, 31), pick_symbol());
            else if (pick < 65)
                set_len($urandom_range(0, 15), $urandom_range(0, 99) < 80 ?
                        $urandom_range(0, 32) : $urandom_range(33, 63));
            else if (pick < 95)
                query(pick_read(), pick_read());
            else
                send_word(OP_UNUSED, 4'($urandom), 5'($urandom), 8'($urandom),
                          6'($urandom), 4'($urandom));
        end
        no_idle = 1'b0;
    endtask

    always @(posedge clk)
    begin : check_results
        overlap_result_t want;
        if (rst_n && done)
        begin
            if (pending_overlaps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: overlap %0d error %0b",
                             overlap_length, index_error);
            end
            else
            begin
                want = pending_overlaps.pop_front();
                if (overlap_length !== want.overlap || index_error !== want.index_error)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected overlap %0d error %0b, got %0d %0b",
                                 want.overlap, want.index_error, overlap_length,
                                 index_error);
                end
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        operation   = spo_pkg::OP_WRITE;
        read_index  = 4'd0;
        position    = 5'd0;
        symbol      = 8'd0;
        read_length = 6'd0;
        second_read = 4'd0;
        cfg_valid   = 1'b0;
        cfg_data    = 5'd0;
        mismatches  = 0;
        words_sent  = 0;
        cycles      = 0;
        no_idle     = 1'b0;
        reads_limit = 5'd0;
        for (int r = 0; r < NUM_READS; r++)
            read_lens[r] = 6'd0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        fill_store();
        test_special_cases();
        test_index_limits();
        test_random_phase(5'd16, 220);
        test_random_phase(5'd31, 220);
        test_random_phase(5'd1, 180);
        test_random_phase(5'd0, 100);
        test_random_phase(5'($urandom_range(2, 15)), 300);
        test_random_phase(5'd16, 290);

        drain();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
